[design/sctf_pkg.sv]
// sctf_pkg: field widths, codes and constants of the sorted can id filter table
// used by the channel interfaces, the table unit and its checker
// no dependencies
package sctf_pkg;

   // field widths
   localparam int FUNC_W  = 1;
   localparam int ID_W    = 16;
   localparam int INDEX_W = 9;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 10;
   localparam int ADDR_W  = COUNT_W + 2;

   typedef logic [ID_W-1:0]    half_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 1'b1;

   // status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // entry constants
   localparam count_type COUNT_MAX    = 10'd1023;
   localparam half_type  ID_SET_BIT   = 16'h2000;
   localparam half_type  ID_KEEP_MASK = 16'hF7FF;
   localparam half_type  PAD_HALF     = 16'hFFFF;

endpackage

[design/sctf_if.sv]
// sctf_req_if, sctf_rsp_if: valid/ready channels of the filter table unit
// depends on sctf_pkg for field widths
interface sctf_req_if;
   logic                          valid;
   logic                          ready;
   logic [sctf_pkg::FUNC_W-1:0]   func;
   logic [sctf_pkg::ID_W-1:0]     id;
   logic [sctf_pkg::INDEX_W-1:0]  word_index;

   modport source (output valid, output func, output id, output word_index, input ready);
   modport sink   (input valid, input func, input id, input word_index, output ready);
endinterface

interface sctf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [sctf_pkg::WORD_W-1:0]   table_word;
   logic [sctf_pkg::COUNT_W-1:0]  entry_count;
   logic [sctf_pkg::ADDR_W-1:0]   table_end_address;

   modport source (output valid, output status, output table_word, output entry_count,
                   output table_end_address, input ready);
   modport sink   (input valid, input status, input table_word, input entry_count,
                   input table_end_address, output ready);
endinterface

[design/sorted_can_id_filter_table_unit.sv]
// sorted_can_id_filter_table_unit: ascending table of 16-bit standard id filter
// entries, two per word, with a single-port sequencer for insert and read
// depends on sctf_pkg and the channel interfaces in sctf_if.sv
//
// Usage
//   req_port carries one command per transfer: func insert puts id (bit 13 set,
//   bit 11 cleared) into the sorted table after any equal entries; func read
//   returns table word word_index. rsp_port returns exactly one result per
//   command: status, table_word, entry_count and table_end_address.
// Sequence
//   A read passes through ST_RD_WAIT, where the registered memory word is
//   taken, and ST_RESULT. An insert reads and compares table words in turn
//   (ST_SEARCH, ST_CHECK), then moves each later word by one memory read and
//   then one write (ST_SHIFT_RD, ST_SHIFT_WR), and for an even entry count
//   writes a padded new last word. The table memory takes a single access per
//   cycle. A refused insert goes straight to ST_RESULT.
//   req_port.ready is high only while no command is in progress.
// Reset
//   Synchronous reset empties the table (entry count zero); no clearing pass.
// Stall
//   The result waits in an output register; the next command is taken while it
//   waits, and that command's result holds until rsp_port.ready frees it.
module sorted_can_id_filter_table_unit #(
   parameter int TABLE_WORDS = 512
) (
   input  logic           clock,
   input  logic           reset,
   sctf_req_if.sink       req_port,
   sctf_rsp_if.source     rsp_port
);
   import sctf_pkg::*;

   localparam int AW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;

   // sequencer state codes
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_RD_WAIT  = 3'd1;
   localparam logic [2:0] ST_SEARCH   = 3'd2;
   localparam logic [2:0] ST_CHECK    = 3'd3;
   localparam logic [2:0] ST_SHIFT_RD = 3'd4;
   localparam logic [2:0] ST_SHIFT_WR = 3'd5;
   localparam logic [2:0] ST_RESULT   = 3'd6;

   // control registers
   logic [2:0]   state_ff, state_in;
   count_type    count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [AW-1:0] w_ff, w_in;
   logic [AW-1:0] used_ff, used_in;
   logic [AW-1:0] last_ff, last_in;
   logic          odd_ff, odd_in;
   logic          hit_ff, hit_in;
   half_type      key_ff, key_in;
   half_type      carry_ff, carry_in;
   logic          res_status_ff, res_status_in;
   word_type      res_word_ff, res_word_in;

   // output registers
   logic          rsp_status_ff, rsp_status_in;
   word_type      rsp_word_ff, rsp_word_in;
   count_type     rsp_count_ff, rsp_count_in;
   logic [ADDR_W-1:0] rsp_end_ff, rsp_end_in;

   // table memory
   word_type      mem_ff [TABLE_WORDS];
   word_type      rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   word_type      wr_data;

   // derived values
   logic [COUNT_W:0]  count_p1;
   count_type         used_words;
   logic              table_full;
   logic              req_xfer;
   logic              rsp_free;
   half_type          rd_hi;
   half_type          rd_lo;

   assign count_p1   = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign used_words = count_p1[COUNT_W:1];
   assign table_full = (int'(used_words) >= TABLE_WORDS) || (count_ff == COUNT_MAX);
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_xfer   = req_port.valid && req_port.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_port.ready;
   assign rd_hi      = rd_data_ff[WORD_W-1:ID_W];
   assign rd_lo      = rd_data_ff[ID_W-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      w_in          = w_ff;
      used_in       = used_ff;
      last_in       = last_ff;
      odd_in        = odd_ff;
      hit_in        = hit_ff;
      key_in        = key_ff;
      carry_in      = carry_ff;
      res_status_in = res_status_ff;
      res_word_in   = res_word_ff;
      rd_en         = 1'b0;
      rd_addr       = w_ff;
      wr_en         = 1'b0;
      wr_addr       = w_ff;
      wr_data       = {carry_ff, rd_hi};
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_status_in = STATUS_DONE;
               res_word_in   = '0;
               if (req_port.func == FUNC_READ) begin
                  hit_in  = int'(req_port.word_index) < TABLE_WORDS;
                  rd_en   = 1'b1;
                  rd_addr = AW'(req_port.word_index);
                  state_in = ST_RD_WAIT;
               end else if (table_full) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_RESULT;
               end else begin
                  key_in   = (req_port.id | ID_SET_BIT) & ID_KEEP_MASK;
                  used_in  = AW'(used_words);
                  last_in  = AW'(count_ff >> 1);
                  odd_in   = count_ff[0];
                  w_in     = '0;
                  carry_in = (req_port.id | ID_SET_BIT) & ID_KEEP_MASK;
                  // empty table: the first entry goes straight to word zero
                  state_in = (count_ff == '0) ? ST_SHIFT_RD : ST_SEARCH;
               end
            end
         end
         ST_RD_WAIT: begin
            res_word_in = hit_ff ? rd_data_ff : '0;
            state_in    = ST_RESULT;
         end
         ST_SEARCH: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ((rd_hi > key_ff) || (rd_lo > key_ff)) begin
               // place the new entry and carry the pushed-out low half onward
               wr_en    = 1'b1;
               wr_data  = (rd_hi > key_ff) ? {key_ff, rd_hi} : {rd_hi, key_ff};
               carry_in = rd_lo;
               if (w_ff == last_ff) begin
                  count_in = count_p1[COUNT_W-1:0];
                  state_in = ST_RESULT;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = ST_SHIFT_RD;
               end
            end else if (w_ff == used_ff - 1'b1) begin
               // no entry is larger: append at the next word
               carry_in = key_ff;
               w_in     = used_ff;
               state_in = ST_SHIFT_RD;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SHIFT_RD: begin
            if ((w_ff == last_ff) && !odd_ff) begin
               // new last word with a padded low half
               wr_en    = 1'b1;
               wr_data  = {carry_ff, PAD_HALF};
               count_in = count_p1[COUNT_W-1:0];
               state_in = ST_RESULT;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_data  = {carry_ff, rd_hi};
            carry_in = rd_lo;
            if (w_ff == last_ff) begin
               count_in = count_p1[COUNT_W-1:0];
               state_in = ST_RESULT;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = ST_SHIFT_RD;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_end_in    = rsp_end_ff;
      if ((state_ff == ST_RESULT) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_word_in   = res_word_ff;
         rsp_count_in  = count_ff;
         rsp_end_in    = {used_words, 2'b00};
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      w_ff          <= w_in;
      used_ff       <= used_in;
      last_ff       <= last_in;
      odd_ff        <= odd_in;
      hit_ff        <= hit_in;
      key_ff        <= key_in;
      carry_ff      <= carry_in;
      res_status_ff <= res_status_in;
      res_word_ff   <= res_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_end_ff    <= rsp_end_in;
   end

   // table memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.status            = rsp_status_ff;
   assign rsp_port.table_word        = rsp_word_ff;
   assign rsp_port.entry_count       = rsp_count_ff;
   assign rsp_port.table_end_address = rsp_end_ff;

endmodule

[design/sctf_checker.sv]
// sctf_checker: port-level checks of the sorted can id filter table unit
// depends on sctf_pkg; bound to sorted_can_id_filter_table_unit below
module sctf_checker #(
   parameter int TABLE_WORDS = 512
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_status,
   input logic [sctf_pkg::WORD_W-1:0]   rsp_table_word,
   input logic [sctf_pkg::COUNT_W-1:0]  rsp_entry_count,
   input logic [sctf_pkg::ADDR_W-1:0]   rsp_table_end_address
);
   import sctf_pkg::*;

   logic [COUNT_W:0] count_p1;
   assign count_p1 = {1'b0, rsp_entry_count} + {{COUNT_W{1'b0}}, 1'b1};

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_table_word)
         && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("result changed while stalled");

   // one command at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while busy");

   // end address follows the entry count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_table_end_address == {count_p1[COUNT_W:1], 2'b00})
      else $error("end address does not match entry count");

   // a refused insert returns no word and only when the table is full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_table_word == '0)
         && ((rsp_entry_count == COUNT_MAX)
             || (int'(count_p1[COUNT_W:1]) >= TABLE_WORDS)))
      else $error("refused insert with table not full");

endmodule

bind sorted_can_id_filter_table_unit sctf_checker #(
   .TABLE_WORDS(TABLE_WORDS)
) u_sctf_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_port.valid),
   .req_ready             (req_port.ready),
   .rsp_valid             (rsp_port.valid),
   .rsp_ready             (rsp_port.ready),
   .rsp_status            (rsp_port.status),
   .rsp_table_word        (rsp_port.table_word),
   .rsp_entry_count       (rsp_port.entry_count),
   .rsp_table_end_address (rsp_port.table_end_address)
);

[bench/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench of the sorted can id filter table unit
// depends on sctf_pkg, the channel interfaces in sctf_if.sv and the table unit
module testbench;
   import sctf_pkg::*;

   localparam int TABLE_DEPTH  = 512;
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int RANDOM_ITEMS = 340;
   localparam int FINAL_READS  = 40;
   localparam int DRAIN_CYCLES = 40;
   localparam int IDLE_PERCENT = 37;

   typedef struct packed {
      logic                status;
      word_type            table_word;
      count_type           entry_count;
      logic [ADDR_W-1:0]   end_address;
   } filter_result_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      half_type            raw_id;
      logic [INDEX_W-1:0]  word_index;
      logic                typed;
      filter_result_type   result;
   } stimulus_row_type;

   localparam int DIRECTED_ROWS = 20;

   // opening rows: typed results only where the value is obvious
   localparam stimulus_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{FUNC_INSERT, 16'h0000, 9'd0, 1'b1, '{STATUS_DONE, 32'h0000_0000, 10'd1, 12'd4}},
      '{FUNC_READ,   16'h0000, 9'd0, 1'b1, '{STATUS_DONE, 32'h2000_FFFF, 10'd1, 12'd4}},
      '{FUNC_INSERT, 16'hFFFF, 9'd0, 1'b1, '{STATUS_DONE, 32'h0000_0000, 10'd2, 12'd4}},
      '{FUNC_READ,   16'hFFFF, 9'd0, 1'b1, '{STATUS_DONE, 32'h2000_F7FF, 10'd2, 12'd4}},
      '{FUNC_INSERT, 16'h0800, 9'd0, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd0, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd1, 1'b0, '0},
      '{FUNC_INSERT, 16'h1234, 9'd0, 1'b0, '0},
      '{FUNC_INSERT, 16'hDFFF, 9'd0, 1'b0, '0},
      '{FUNC_INSERT, 16'h2000, 9'd0, 1'b0, '0},
      '{FUNC_INSERT, 16'hA5A5, 9'd0, 1'b0, '0},
      '{FUNC_INSERT, 16'h5A5A, 9'd0, 1'b0, '0},
      '{FUNC_INSERT, 16'hC000, 9'd0, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd0, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd1, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd2, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd3, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd4, 1'b0, '0},
      '{FUNC_INSERT, 16'h0000, 9'd0, 1'b0, '0},
      '{FUNC_READ,   16'h0000, 9'd4, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;
   logic no_gaps;

   sctf_req_if req_bus ();
   sctf_rsp_if rsp_bus ();

   sorted_can_id_filter_table_unit #(
      .TABLE_WORDS (TABLE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // shadow of the filter table
   word_type          id_table [TABLE_DEPTH];
   bit                word_seen [TABLE_DEPTH];
   int unsigned       held_total;
   filter_result_type pending_results [$];
   half_type          recent_ids [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic word_type table_read(int unsigned w);
      if (w >= TABLE_DEPTH || !word_seen[w]) return '0;
      return id_table[w];
   endfunction

   function automatic void table_write(int unsigned w, word_type value);
      if (w >= TABLE_DEPTH) return;
      id_table[w]  = value;
      word_seen[w] = 1'b1;
   endfunction

   // next table state and the result of one command
   function automatic filter_result_type filter_table_step(logic [FUNC_W-1:0] func,
                                                           half_type raw_id,
                                                           logic [INDEX_W-1:0] widx);
      filter_result_type r;
      int unsigned       n, used, w, pos, last;
      half_type          id;
      word_type          word, buf0, buf1;
      bit                found;
      r = '0;
      if (func == FUNC_INSERT) begin
         n = held_total;
         if (((n + 1) >> 1) >= TABLE_DEPTH || n >= COUNT_MAX) begin
            r.status = STATUS_FULL;
         end else begin
            id    = (raw_id | ID_SET_BIT) & ID_KEEP_MASK;
            used  = (n + 1) >> 1;
            pos   = n;
            found = 1'b0;
            w     = 0;
            // first held entry strictly greater than the new one
            while (!found && w < used) begin
               word = table_read(w);
               if (word[31:16] > id) begin
                  pos   = 2 * w;
                  found = 1'b1;
               end else if (word[15:0] > id) begin
                  pos   = 2 * w + 1;
                  found = 1'b1;
               end else begin
                  w++;
               end
            end
            if (!found) begin
               // append at the end of the table
               if (n[0] == 1'b0) begin
                  table_write(w, {id, PAD_HALF});
               end else begin
                  word = table_read(w);
                  table_write(w, {word[31:16], id});
               end
            end else begin
               buf0 = table_read(w);
               if (pos[0] == 1'b0) buf1 = {id, buf0[31:16]};
               else buf1 = {buf0[31:16], id};
               table_write(w, buf1);
               // shift later entries up by one half
               last = n >> 1;
               while (w < last) begin
                  w++;
                  buf1 = table_read(w);
                  table_write(w, {buf0[15:0], buf1[31:16]});
                  buf0 = buf1;
               end
               if (n[0] == 1'b0) begin
                  word = table_read(w);
                  table_write(w, {word[31:16], PAD_HALF});
               end
            end
            held_total = (n + 1) & 10'h3FF;
         end
      end else begin
         r.table_word = table_read(widx);
      end
      r.entry_count = count_type'(held_total);
      r.end_address = ADDR_W'(((held_total + 1) >> 1) << 2);
      return r;
   endfunction

   // identifier mix: repeats of earlier ones, extremes, random values
   function automatic half_type pick_id();
      int unsigned roll;
      half_type    id;
      roll = $urandom_range(99);
      if (roll < 25 && recent_ids.size() > 0)
         id = recent_ids[$urandom_range(recent_ids.size() - 1)];
      else if (roll < 30)
         id = 16'h0000;
      else if (roll < 35)
         id = 16'hFFFF;
      else
         id = half_type'($urandom);
      recent_ids.push_back(id);
      if (recent_ids.size() > 16) void'(recent_ids.pop_front());
      return id;
   endfunction

   // only words already written are read
   function automatic logic [INDEX_W-1:0] pick_index();
      int unsigned used, roll;
      used = (held_total + 1) >> 1;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return INDEX_W'(used - 1);
      return INDEX_W'($urandom_range(used - 1));
   endfunction

   // one command transfer, with random idle cycles ahead of it
   task automatic send_command(input logic [FUNC_W-1:0] func, input half_type raw_id,
                               input logic [INDEX_W-1:0] widx, input logic typed,
                               input filter_result_type typed_result);
      filter_result_type predicted;
      while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= func;
      req_bus.id         <= raw_id;
      req_bus.word_index <= widx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = filter_table_step(func, raw_id, widx);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // result consumer stalls at random except in the steady window
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // result checking against the oldest prediction
   always @(posedge clock) begin : result_check
      filter_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result with nothing expected, actual status %b word %h count %0d",
                     $time, rsp_bus.status, rsp_bus.table_word, rsp_bus.entry_count);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", want.status, rsp_bus.status);
            compare_field("table_word", want.table_word, rsp_bus.table_word);
            compare_field("entry_count", want.entry_count, rsp_bus.entry_count);
            compare_field("table_end_address", want.end_address, rsp_bus.table_end_address);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned i;
      int unsigned drain;
      reset              = 1'b1;
      no_gaps            = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_INSERT;
      req_bus.id         = '0;
      req_bus.word_index = '0;
      held_total         = 0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         id_table[i]  = '0;
         word_seen[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_command(DIRECTED[i].func, DIRECTED[i].raw_id, DIRECTED[i].word_index,
                      DIRECTED[i].typed, DIRECTED[i].result);
      end

      // random mix of inserts and reads, with one stretch free of gaps
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         no_gaps <= (i >= 150 && i < 250);
         if (held_total == 0 || $urandom_range(99) < 60)
            send_command(FUNC_INSERT, pick_id(), INDEX_W'($urandom), 1'b0, '0);
         else
            send_command(FUNC_READ, half_type'($urandom), pick_index(), 1'b0, '0);
      end

      // reads across the written part of the table
      for (i = 0; i < FINAL_READS; i++) begin
         send_command(FUNC_READ, half_type'($urandom), pick_index(), 1'b0, '0);
      end

      req_bus.valid <= 1'b0;
      no_gaps       <= 1'b0;

      // drain outstanding results
      while (pending_results.size() != 0) @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[sorted_can_id_filter_table_unit.f]
design/sctf_pkg.sv
design/sctf_if.sv
design/sorted_can_id_filter_table_unit.sv
design/sctf_checker.sv
bench/testbench.sv
